@@ rtl/fat_pkg.sv @@
// Shared types, constants and the gamma threshold table of the film accumulator.
`timescale 1ns / 1ps
package fat_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int PIXELS     = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = (PIXELS > 1) ? $clog2(PIXELS) : 1;

	localparam int SUM_W      = 40;
	localparam int SAMPLE_W   = 24;
	localparam int GAIN_W     = 16;
	localparam int PASS_W     = 16;
	localparam int FRAME_W    = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int WORD_W     = 3 * SUM_W;

	// Command codes
	localparam logic [1:0] CMD_SPLAT    = 2'd0;
	localparam logic [1:0] CMD_END_PASS = 2'd1;
	localparam logic [1:0] CMD_READ     = 2'd2;
	localparam logic [1:0] CMD_CLEAR    = 2'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXPOSURE     = 2'd2;

	// Curve constants: C(v) = v(42v+5)/(45v^2+150v+18), scaled to Q.16
	localparam logic [46:0] WHITE_V5  = 47'd3670016;
	localparam logic [16:0] WHITE_NUM = 17'd91785;
	localparam logic [16:0] WHITE_DEN = 17'd66556;
	localparam logic [25:0] NUM_LIN   = 26'd327680;
	localparam logic [63:0] DEN_LIN   = 64'd9830400;
	localparam logic [63:0] DEN_CONST = 64'd77309411328;

	typedef struct packed {
		logic              start;
		logic [SUM_W-1:0]  sum;
		logic [GAIN_W-1:0] gain;
		logic [PASS_W-1:0] pass;
	} fat_tone_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] code;
	} fat_tone_rsp_t;

	function automatic logic [175:0] pow_n(input logic [175:0] b, input int n);
		logic [175:0] r;
		r = 176'd1;
		for (int i = 0; i < 11; i++) begin
			if (i < n) r = r * b;
		end
		return r;
	endfunction

	// Entry k: smallest T (Q0.16) with T^5 * 255^11 >= k^11 * 2^80
	function automatic logic [255:0][16:0] gamma_thr_table();
		logic [255:0][16:0] tab;
		logic [175:0]       rhs;
		logic [175:0]       c255;
		logic [16:0]        lo;
		logic [16:0]        hi;
		logic [16:0]        mid;
		c255 = pow_n(176'd255, 11);
		for (int k = 0; k < 256; k++) begin
			rhs = pow_n(176'(k), 11) << 80;
			lo  = 17'd0;
			hi  = 17'd65536;
			for (int s = 0; s < 17; s++) begin
				if (lo < hi) begin
					mid = 17'((18'(lo) + 18'(hi)) >> 1);
					if (pow_n(176'(mid), 5) * c255 >= rhs) hi = mid;
					else lo = mid + 17'd1;
				end
			end
			tab[k] = lo;
		end
		return tab;
	endfunction

	localparam logic [255:0][16:0] GAMMA_THR = gamma_thr_table();

endpackage

@@ rtl/fat_if.sv @@
// Request and pixel channel interfaces.
`timescale 1ns / 1ps
interface fat_sample_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic [23:0]        sample_red;
	logic [23:0]        sample_green;
	logic [23:0]        sample_blue;
	modport source (output valid, command, pos_x, pos_y, sample_red, sample_green,
		sample_blue, input ready);
	modport sink (input valid, command, pos_x, pos_y, sample_red, sample_green,
		sample_blue, output ready);
endinterface

interface fat_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic       read_status;
	modport source (output valid, red_out, green_out, blue_out, read_status, input ready);
	modport sink (input valid, red_out, green_out, blue_out, read_status, output ready);
endinterface

@@ rtl/fat_tone.sv @@
// Per-channel readout: mean, exposure, filmic curve and gamma byte search.
`timescale 1ns / 1ps
module fat_tone (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fat_pkg::fat_tone_req_t req,
	output fat_pkg::fat_tone_rsp_t rsp
);
	import fat_pkg::*;

	typedef enum logic [3:0] {
		T_IDLE, T_DIV, T_CHK, T_P1, T_P2, T_P3, T_FRAC, T_GAM
	} tstate_t;

	tstate_t      state_q;
	logic         done_q;
	logic [7:0]   code_q;
	logic [5:0]   cnt_q;
	logic [43:0]  dvd_q;
	logic [15:0]  rem_q;
	logic [15:0]  div_q;
	logic [19:0]  v_q;
	logic [25:0]  a_q;
	logic [39:0]  sq_q;
	logic [45:0]  num_q;
	logic [63:0]  den_q;
	logic [64:0]  r_q;
	logic [15:0]  t_q;
	logic [7:0]   lo_q;
	logic [7:0]   hi_q;

	logic [55:0]  prod;
	logic [16:0]  rem_sh;
	logic         rem_ge;
	logic [64:0]  r_sh;
	logic         r_ge;
	logic [7:0]   mid;

	always_comb begin
		prod   = 56'(req.sum) * 56'(req.gain);
		rem_sh = {rem_q, dvd_q[43]};
		rem_ge = rem_sh >= {1'b0, div_q};
		r_sh   = {r_q[63:0], 1'b0};
		r_ge   = r_sh >= {1'b0, den_q};
		mid    = 8'((9'(lo_q) + 9'(hi_q) + 9'd1) >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			done_q  <= 1'b0;
			code_q  <= 8'd0;
			cnt_q   <= 6'd0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				T_IDLE: begin
					if (req.start) begin
						if (req.pass == '0) begin
							code_q <= 8'd0;
							done_q <= 1'b1;
						end else begin
							dvd_q   <= prod[55:12];
							rem_q   <= 16'd0;
							div_q   <= req.pass;
							cnt_q   <= 6'd0;
							state_q <= T_DIV;
						end
					end
				end
				T_DIV: begin
					rem_q <= rem_ge ? 16'(rem_sh - {1'b0, div_q}) : rem_sh[15:0];
					dvd_q <= {dvd_q[42:0], rem_ge};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd43) state_q <= T_CHK;
				end
				T_CHK: begin
					if (47'(dvd_q) * 47'd5 >= WHITE_V5) begin
						code_q  <= 8'd255;
						done_q  <= 1'b1;
						state_q <= T_IDLE;
					end else begin
						v_q     <= dvd_q[19:0];
						state_q <= T_P1;
					end
				end
				T_P1: begin
					a_q     <= 26'(26'(v_q) * 26'd42 + NUM_LIN);
					sq_q    <= 40'(v_q) * 40'(v_q);
					state_q <= T_P2;
				end
				T_P2: begin
					num_q   <= 46'(v_q) * 46'(a_q);
					den_q   <= 64'(sq_q) * 64'd45 + DEN_LIN * 64'(v_q) + DEN_CONST;
					state_q <= T_P3;
				end
				T_P3: begin
					r_q     <= {1'b0, 64'(num_q) * 64'(WHITE_NUM)};
					den_q   <= 64'(den_q[46:0]) * 64'(WHITE_DEN);
					cnt_q   <= 6'd0;
					state_q <= T_FRAC;
				end
				T_FRAC: begin
					r_q   <= r_ge ? r_sh - {1'b0, den_q} : r_sh;
					t_q   <= {t_q[14:0], r_ge};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd15) begin
						lo_q    <= 8'd0;
						hi_q    <= 8'd255;
						state_q <= T_GAM;
					end
				end
				T_GAM: begin
					if (lo_q == hi_q) begin
						code_q  <= lo_q;
						done_q  <= 1'b1;
						state_q <= T_IDLE;
					end else if (GAMMA_THR[mid] <= {1'b0, t_q}) begin
						lo_q <= mid;
					end else begin
						hi_q <= mid - 8'd1;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.code = code_q;

endmodule

@@ rtl/film_accumulate_tonemap.sv @@
// Top level: RGB accumulation film in one memory, pass counter and filmic readout.
`timescale 1ns / 1ps
//
//  channel     dir   handshake      payload
//  sample_ch   in    valid/ready    command, pos_x, pos_y, sample_red/green/blue
//  pixel_ch    out   valid/ready    red_out, green_out, blue_out, read_status
//  cfg         in    cfg_we         cfg_index, cfg_data (no read-back)
//
//  One request at a time. end_pass only bumps the pass counter, a splat does a
//  memory read, then a saturating write back, and a clear writes zero to every pixel.
//  A read runs the three channels through one tone unit: per channel a multiply,
//  a 44-step divide, the check and product states, a 16-step fraction divide and
//  a binary byte search, cut short for a zero pass count or a white clip; the divider loop dominates.
//  After reset the film is swept to zero, all 4096 pixels, with ready low.
//  A finished pixel waits in the output register; the next request is taken
//  meanwhile, and a second read result holds until the first is drained.
//
module film_accumulate_tonemap (
	input  logic                             clk,
	input  logic                             arst_n,
	fat_sample_if.sink                       sample_ch,
	fat_pixel_if.source                      pixel_ch,
	input  logic                             cfg_we,
	input  logic [fat_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fat_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import fat_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_SPLAT, ST_FETCH, ST_TONE, ST_DONE
	} state_t;

	state_t              state_q;
	logic [FRAME_W-1:0]  frame_width_q;
	logic [FRAME_W-1:0]  frame_height_q;
	logic [GAIN_W-1:0]   gain_q;
	logic [PASS_W-1:0]   pass_q;
	logic [ADDR_W-1:0]   clr_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [SAMPLE_W-1:0] red_q;
	logic [SAMPLE_W-1:0] green_q;
	logic [SAMPLE_W-1:0] blue_q;
	logic                status_q;
	logic [1:0]          ch_q;
	logic                start_q;
	logic [7:0]          red_byte_q;
	logic [7:0]          green_byte_q;
	logic [7:0]          blue_byte_q;

	logic                out_valid_q;
	logic [7:0]          out_red_q;
	logic [7:0]          out_green_q;
	logic [7:0]          out_blue_q;
	logic                out_status_q;

	// film memory: {blue, green, red} sums per pixel
	logic [WORD_W-1:0]   mem [PIXELS];
	logic [WORD_W-1:0]   mem_rdata_q;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [WORD_W-1:0]   mem_wdata;
	logic                mem_re;

	logic                accept;
	logic [15:0]         w_lim;
	logic [15:0]         h_lim;
	logic                pos_ok;
	logic [ADDR_W-1:0]   in_addr;
	logic [SUM_W:0]      add_r;
	logic [SUM_W:0]      add_g;
	logic [SUM_W:0]      add_b;
	logic                out_free;
	logic                out_load;

	fat_tone_req_t       tone_req;
	fat_tone_rsp_t       tone_rsp;

	assign sample_ch.ready = (state_q == ST_IDLE);
	assign accept          = sample_ch.valid && sample_ch.ready;
	assign out_free        = !out_valid_q || pixel_ch.ready;
	assign out_load        = (state_q == ST_DONE) && out_free;

	// frame limits and position check on the incoming request
	always_comb begin
		w_lim   = (32'(frame_width_q) < MAX_WIDTH) ? 16'(frame_width_q) : 16'(MAX_WIDTH);
		h_lim   = (32'(frame_height_q) < MAX_HEIGHT) ? 16'(frame_height_q) : 16'(MAX_HEIGHT);
		pos_ok  = !sample_ch.pos_x[15] && (sample_ch.pos_x[15:0] < w_lim) &&
			!sample_ch.pos_y[15] && (sample_ch.pos_y[15:0] < h_lim);
		in_addr = ADDR_W'(32'(sample_ch.pos_y[14:0]) * MAX_WIDTH +
			32'(sample_ch.pos_x[14:0]));
	end

	// saturating add of the held sample onto the fetched sums
	always_comb begin
		add_r = {1'b0, mem_rdata_q[SUM_W-1:0]} + (SUM_W+1)'(red_q);
		add_g = {1'b0, mem_rdata_q[2*SUM_W-1:SUM_W]} + (SUM_W+1)'(green_q);
		add_b = {1'b0, mem_rdata_q[3*SUM_W-1:2*SUM_W]} + (SUM_W+1)'(blue_q);
	end

	// write port: zero sweep while clearing, else splat write back
	always_comb begin
		mem_we    = (state_q == ST_CLEAR) || (state_q == ST_SPLAT);
		mem_waddr = (state_q == ST_CLEAR) ? clr_q : addr_q;
		mem_wdata = '0;
		if (state_q == ST_SPLAT) begin
			mem_wdata = {add_b[SUM_W] ? {SUM_W{1'b1}} : add_b[SUM_W-1:0],
				add_g[SUM_W] ? {SUM_W{1'b1}} : add_g[SUM_W-1:0],
				add_r[SUM_W] ? {SUM_W{1'b1}} : add_r[SUM_W-1:0]};
		end
		mem_re = accept && pos_ok &&
			((sample_ch.command == CMD_SPLAT) || (sample_ch.command == CMD_READ));
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) mem_rdata_q <= mem[in_addr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_W'(MAX_WIDTH < 64 ? MAX_WIDTH : 64);
			frame_height_q <= FRAME_W'(64);
			gain_q         <= 16'd4096;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FRAME_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FRAME_W-1:0];
				REG_EXPOSURE:     gain_q         <= cfg_data;
				default: ;
			endcase
		end
	end

	// hand the current channel sum to the tone unit
	always_comb begin
		tone_req.start = start_q;
		tone_req.gain  = gain_q;
		tone_req.pass  = pass_q;
		case (ch_q)
			2'd0:    tone_req.sum = mem_rdata_q[SUM_W-1:0];
			2'd1:    tone_req.sum = mem_rdata_q[2*SUM_W-1:SUM_W];
			default: tone_req.sum = mem_rdata_q[3*SUM_W-1:2*SUM_W];
		endcase
	end

	fat_tone u_tone (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tone_req),
		.rsp    (tone_rsp)
	);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			pass_q      <= '0;
			ch_q        <= 2'd0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			// load a finished pixel, else drop the one just taken
			if (out_load) out_valid_q <= 1'b1;
			else if (pixel_ch.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(PIXELS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						addr_q  <= in_addr;
						red_q   <= sample_ch.sample_red;
						green_q <= sample_ch.sample_green;
						blue_q  <= sample_ch.sample_blue;
						unique case (sample_ch.command)
							CMD_SPLAT: begin
								if (pos_ok) state_q <= ST_SPLAT;
							end
							CMD_END_PASS: begin
								if (pass_q != '1) pass_q <= pass_q + PASS_W'(1);
							end
							CMD_READ: begin
								if (pos_ok) begin
									state_q <= ST_FETCH;
								end else begin
									red_byte_q   <= 8'd0;
									green_byte_q <= 8'd0;
									blue_byte_q  <= 8'd0;
									status_q     <= 1'b1;
									state_q      <= ST_DONE;
								end
							end
							CMD_CLEAR: begin
								pass_q  <= '0;
								clr_q   <= '0;
								state_q <= ST_CLEAR;
							end
							default: ;
						endcase
					end
				end
				ST_SPLAT: state_q <= ST_IDLE;
				ST_FETCH: begin
					ch_q     <= 2'd0;
					start_q  <= 1'b1;
					status_q <= 1'b0;
					state_q  <= ST_TONE;
				end
				ST_TONE: begin
					if (tone_rsp.done) begin
						case (ch_q)
							2'd0:    red_byte_q   <= tone_rsp.code;
							2'd1:    green_byte_q <= tone_rsp.code;
							default: blue_byte_q  <= tone_rsp.code;
						endcase
						if (ch_q == 2'd2) begin
							state_q <= ST_DONE;
						end else begin
							ch_q    <= ch_q + 2'd1;
							start_q <= 1'b1;
						end
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						out_red_q    <= red_byte_q;
						out_green_q  <= green_byte_q;
						out_blue_q   <= blue_byte_q;
						out_status_q <= status_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign pixel_ch.valid       = out_valid_q;
	assign pixel_ch.red_out     = out_red_q;
	assign pixel_ch.green_out   = out_green_q;
	assign pixel_ch.blue_out    = out_blue_q;
	assign pixel_ch.read_status = out_status_q;

endmodule

@@ rtl/fat_checker.sv @@
// Port-level assertions for the film accumulator, bound to the top level.
`timescale 1ns / 1ps
module fat_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] command,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] red_out,
	input logic [7:0] green_out,
	input logic [7:0] blue_out,
	input logic       read_status
);
	import fat_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red_out) &&
		$stable(green_out) && $stable(blue_out) && $stable(read_status))
		else $error("pixel changed while stalled");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_status |-> red_out == 8'd0 && green_out == 8'd0 &&
		blue_out == 8'd0)
		else $error("outside pixel with nonzero bytes");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (command == CMD_READ || command == CMD_CLEAR)
		|=> !in_ready)
		else $error("read or clear did not hold off requests");

	a_pass_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == CMD_END_PASS |=> in_ready)
		else $error("end_pass stalled the request channel");

endmodule

bind film_accumulate_tonemap fat_checker u_fat_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (sample_ch.valid),
	.in_ready    (sample_ch.ready),
	.command     (sample_ch.command),
	.out_valid   (pixel_ch.valid),
	.out_ready   (pixel_ch.ready),
	.red_out     (pixel_ch.red_out),
	.green_out   (pixel_ch.green_out),
	.blue_out    (pixel_ch.blue_out),
	.read_status (pixel_ch.read_status)
);
